// ===== sv/qgram_profile_distance_macros.svh =====
// Assertion macros used by the checker file of the q-gram distance block.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef QGRAM_PROFILE_DISTANCE_MACROS_SVH
`define QGRAM_PROFILE_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QPD_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define QPD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/qpd_pkg.sv =====
// Shared constants for the q-gram profile distance block.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package qpd_pkg;

    localparam int SYMBOL_BITS = 2;
    localparam int MAX_Q       = 6;
    localparam int COUNT_BITS  = 21;

    localparam int SYMBOL_W    = 2;
    localparam int Q_W         = 3;
    localparam int FILL_W      = 3;
    localparam int CODE_BITS   = SYMBOL_BITS * MAX_Q;
    localparam int TABLE_DEPTH = 1 << CODE_BITS;
    localparam int DIST_BITS   = 22;
    localparam int ACC_BITS    = DIST_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0]  DIST_MAX  = {DIST_BITS{1'b1}};
    localparam logic [Q_W-1:0]        Q_MAX     = Q_W'(MAX_Q);
    localparam logic [Q_W-1:0]        Q_RESET   = Q_W'(3);

endpackage

// ===== sv/qgram_profile_distance.sv =====
// Top level of the q-gram profile distance block: window, profile RAMs, sum sweep.
// Depends on qpd_pkg.
`timescale 1ns / 1ps

// Channel      Ports                          Handshake
// ----------   ----------------------------   ------------------------------
// request      cmd, symbol, last              start high, busy low at edge
// result       distance, saturated            done strobe, one cycle, no stall
// config       cfg_wdata (gram_length)        cfg_we high at edge
//
// A symbol that completes no q-gram needs no update state; one that
// completes a q-gram passes through ST_UPDATE, since the profile RAM read
// is registered, and the incremented count is written back through the
// write port. The last symbol of sequence B then starts a sweep over all
// 4096 entries of both tables that sums the differences and zeroes each
// entry behind it; a drain state follows and done pulses in the emit state
// after it, with busy high throughout. After reset a clearing pass over
// all entries runs with busy high; config writes are taken at any time.

module qgram_profile_distance
    import qpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [SYMBOL_W-1:0]   symbol,
    input  logic                  last,
    input  logic                  cfg_we,
    input  logic [Q_W-1:0]        cfg_wdata,
    output logic                  done,
    output logic [DIST_BITS-1:0]  distance,
    output logic                  saturated
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_SUM    = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_EMIT   = 6'b100000
    } qpd_state_t;

    qpd_state_t              state_reg, state_next;
    logic [Q_W-1:0]          q_len_reg;
    logic [CODE_BITS-1:0]    code_reg, code_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [CODE_BITS-1:0]    addr_reg, addr_next;
    logic                    sel_b_reg, sel_b_next;
    logic                    end_b_reg, end_b_next;
    logic                    overflow_reg, overflow_next;
    logic [CODE_BITS-1:0]    cnt_reg, cnt_next;
    logic                    rd_valid_reg;
    logic [ACC_BITS-1:0]     acc_reg, acc_next;

    // Profile tables: one synchronous read port, one write port each
    logic [COUNT_BITS-1:0]   profile_a [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]   profile_b [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]   rd_a_reg, rd_b_reg;
    logic [CODE_BITS-1:0]    rd_addr, wr_addr;
    logic                    wr_a, wr_b;
    logic [COUNT_BITS-1:0]   wr_data;

    logic [Q_W-1:0]          q_eff;
    logic [CODE_BITS-1:0]    mask;
    logic [CODE_BITS-1:0]    win_code;
    logic [FILL_W-1:0]       win_fill;
    logic                    accept;
    logic [COUNT_BITS-1:0]   cur_count;
    logic [COUNT_BITS-1:0]   diff;
    logic [ACC_BITS-1:0]     sum;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Clamp q into 1..MAX_Q
    always_comb
    begin
        if (q_len_reg == '0)
            q_eff = Q_W'(1);
        else if (q_len_reg > Q_MAX)
            q_eff = Q_MAX;
        else
            q_eff = q_len_reg;
    end

    // Shift the new symbol into the window and mask to q symbols
    always_comb
    begin
        mask     = ~({CODE_BITS{1'b1}} << (SYMBOL_BITS * q_eff));
        win_code = ((code_reg << SYMBOL_BITS)
                   | CODE_BITS'(symbol[SYMBOL_BITS-1:0])) & mask;
        if (FILL_W'(q_eff) > fill_reg)
            win_fill = fill_reg + FILL_W'(1);
        else
            win_fill = FILL_W'(q_eff);
    end

    // Saturating sum of absolute differences
    always_comb
    begin
        diff = (rd_a_reg > rd_b_reg) ? (rd_a_reg - rd_b_reg) : (rd_b_reg - rd_a_reg);
        sum  = acc_reg + ACC_BITS'(diff);
        if (sum > ACC_BITS'(DIST_MAX))
            sum = ACC_BITS'(DIST_MAX) + ACC_BITS'(1);
    end

    assign cur_count = sel_b_reg ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        fill_next     = fill_reg;
        addr_next     = addr_reg;
        sel_b_next    = sel_b_reg;
        end_b_next    = end_b_reg;
        overflow_next = overflow_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        rd_addr       = cnt_reg;
        wr_addr       = cnt_reg;
        wr_a          = 1'b0;
        wr_b          = 1'b0;
        wr_data       = '0;

        if (rd_valid_reg)
            acc_next = sum;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_a     = 1'b1;
                wr_b     = 1'b1;
                cnt_next = cnt_reg + CODE_BITS'(1);
                if (cnt_reg == CODE_BITS'(TABLE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                // Issue the read of the q-gram entry at the accept edge
                rd_addr = win_code;
                if (accept)
                begin
                    addr_next  = win_code;
                    sel_b_next = cmd;
                    end_b_next = last && cmd;
                    // Drop the window at the end of either sequence
                    code_next  = last ? '0 : win_code;
                    fill_next  = last ? '0 : win_fill;
                    if (win_fill == FILL_W'(q_eff))
                        state_next = ST_UPDATE;
                    else if (last && cmd)
                        state_next = ST_SUM;
                end
            end
            ST_UPDATE:
            begin
                wr_addr = addr_reg;
                wr_a    = !sel_b_reg;
                wr_b    = sel_b_reg;
                if (cur_count >= COUNT_MAX)
                begin
                    wr_data       = COUNT_MAX;
                    overflow_next = 1'b1;
                end
                else
                begin
                    wr_data = cur_count + COUNT_BITS'(1);
                    if (wr_data == COUNT_MAX)
                        overflow_next = 1'b1;
                end
                state_next = end_b_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                // Read and zero each entry; read returns the old value
                wr_a     = 1'b1;
                wr_b     = 1'b1;
                cnt_next = cnt_reg + CODE_BITS'(1);
                if (cnt_reg == CODE_BITS'(TABLE_DEPTH - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                acc_next      = '0;
                overflow_next = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            q_len_reg    <= Q_RESET;
            code_reg     <= '0;
            fill_reg     <= '0;
            sel_b_reg    <= 1'b0;
            end_b_reg    <= 1'b0;
            overflow_reg <= 1'b0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
                q_len_reg <= cfg_wdata;
            code_reg     <= code_next;
            fill_reg     <= fill_next;
            sel_b_reg    <= sel_b_next;
            end_b_reg    <= end_b_next;
            overflow_reg <= overflow_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= (state_reg == ST_SUM);
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= profile_a[rd_addr];
        if (wr_a)
            profile_a[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_b_reg <= profile_b[rd_addr];
        if (wr_b)
            profile_b[wr_addr] <= wr_data;
    end

    // Clamp the distance; a clamped sum also flags saturation
    assign done      = (state_reg == ST_EMIT);
    assign distance  = acc_reg[DIST_BITS] ? DIST_MAX : acc_reg[DIST_BITS-1:0];
    assign saturated = acc_reg[DIST_BITS] | overflow_reg;

endmodule

// ===== sv/qpd_checker.sv =====
// Port-level checks for the q-gram profile distance block, bound to the top level.
// Depends on qgram_profile_distance_macros.svh.
`timescale 1ns / 1ps
`include "qgram_profile_distance_macros.svh"

module qpd_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  done
);

    `QPD_CHECK_NOW(a_done_while_busy, done, busy, "result strobe while idle")
    `QPD_CHECK_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `QPD_CHECK_NEXT(a_idle_after_done, done, !busy, "block not idle after result")
    `QPD_CHECK_NEXT(a_no_early_result, start && !busy, !done, "result right after request")

endmodule

bind qgram_profile_distance qpd_checker u_qpd_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for qgram_profile_distance: directed table, then random sequence pairs and request bursts.
// Depends on qpd_pkg and the qgram_profile_distance RTL; predicts each distance internally.
`timescale 1ns / 1ps

module tb;
    import qpd_pkg::*;

    typedef enum logic {SEQ_A = 1'b0, SEQ_B = 1'b1} seq_sel_e;
    typedef enum logic {ROW_SYMBOL = 1'b0, ROW_GRAM_LENGTH = 1'b1} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        seq_sel_e              seq;
        logic [SYMBOL_W-1:0]   sym;
        logic                  fin;
        logic [Q_W-1:0]        q_value;
        logic                  typed;
        logic [DIST_BITS-1:0]  exp_dist;
        logic                  sat;
    } stim_row_t;

    typedef struct {
        logic [DIST_BITS-1:0] distance;
        logic                 saturated;
    } distance_t;

    localparam int ROW_COUNT   = 30;
    localparam int SETTLE_CYC  = 8;
    localparam int PAIR_ITEMS  = 400;

    // Directed part. Expected values are typed in on the B-last rows that
    // are obvious by hand; the final row is left to the predictor.
    stim_row_t directed_rows [ROW_COUNT] = '{
        // q = 3 after reset: identical sequences
        '{ROW_SYMBOL, SEQ_A, 2'd0, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd1, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd2, 1'b1, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd0, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd1, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd2, 1'b1, 3'd0, 1'b1, 22'd0, 1'b0},
        // q = 1: A {3,3}, B {0}
        '{ROW_GRAM_LENGTH, SEQ_A, 2'd0, 1'b0, 3'd1, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd3, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd3, 1'b1, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd0, 1'b1, 3'd0, 1'b1, 22'd3, 1'b0},
        // q above range acts as 6: two distinct grams in A, B too short
        '{ROW_GRAM_LENGTH, SEQ_A, 2'd0, 1'b0, 3'd7, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd3, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd2, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd1, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd0, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd3, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd2, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd1, 1'b1, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd1, 1'b1, 3'd0, 1'b1, 22'd2, 1'b0},
        // q = 0 acts as 1; switch A to B without a last mark
        '{ROW_GRAM_LENGTH, SEQ_A, 2'd0, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd2, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd2, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd1, 1'b1, 3'd0, 1'b1, 22'd1, 1'b0},
        // q = 6, then shrink to 2 in the middle of sequence A
        '{ROW_GRAM_LENGTH, SEQ_A, 2'd0, 1'b0, 3'd6, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd1, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd2, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd3, 1'b0, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_GRAM_LENGTH, SEQ_A, 2'd0, 1'b0, 3'd2, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_A, 2'd0, 1'b1, 3'd0, 1'b0, 22'd0, 1'b0},
        '{ROW_SYMBOL, SEQ_B, 2'd0, 1'b1, 3'd0, 1'b0, 22'd0, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  cmd = 1'b0;
    logic [SYMBOL_W-1:0]   symbol = '0;
    logic                  last = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [Q_W-1:0]        cfg_wdata = '0;
    logic                  done;
    logic [DIST_BITS-1:0]  distance;
    logic                  saturated;

    // Hand-typed expectation that travels with the request it belongs to.
    logic                  typed_now = 1'b0;
    logic [DIST_BITS-1:0]  typed_dist = '0;
    logic                  typed_sat = 1'b0;

    // Predictor state.
    logic [Q_W-1:0]        gram_q = Q_RESET;
    logic [CODE_BITS-1:0]  window_code = '0;
    int unsigned           window_len = 0;
    int unsigned           prof_a [TABLE_DEPTH];
    int unsigned           prof_b [TABLE_DEPTH];
    bit                    hit_ceiling = 1'b0;
    logic [DIST_BITS-1:0]  pred_dist;
    logic                  pred_sat;

    distance_t             pending_distances [$];
    int                    mismatches = 0;
    bit                    calm = 1'b0;

    qgram_profile_distance dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .symbol    (symbol),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .distance  (distance),
        .saturated (saturated)
    );

    always #2 clk = ~clk;

    // Fold one accepted symbol into the profiles. Return 1 when it closes
    // sequence B, with the distance and the saturation flag in res_dist / sat.
    function automatic bit tally_symbol(input logic is_b, input logic [SYMBOL_W-1:0] sym,
                                        input logic fin, output logic [DIST_BITS-1:0] res_dist,
                                        output logic sat);
        int unsigned          q;
        logic [CODE_BITS-1:0] mask;
        longint unsigned      total;
        int unsigned          diff;
        res_dist = '0;
        sat = 1'b0;
        q = (gram_q == 0) ? 1 : ((gram_q > Q_MAX) ? MAX_Q : gram_q);
        mask = CODE_BITS'((64'd1 << (SYMBOL_BITS * q)) - 64'd1);
        window_code = (CODE_BITS'(window_code << SYMBOL_BITS) | CODE_BITS'(sym)) & mask;
        if (window_len < q)
            window_len++;
        if (window_len > q)
            window_len = q;

        if (window_len >= q)
        begin
            if (is_b)
            begin
                if (prof_b[window_code] < COUNT_MAX)
                    prof_b[window_code]++;
                if (prof_b[window_code] >= COUNT_MAX)
                    hit_ceiling = 1'b1;
            end
            else
            begin
                if (prof_a[window_code] < COUNT_MAX)
                    prof_a[window_code]++;
                if (prof_a[window_code] >= COUNT_MAX)
                    hit_ceiling = 1'b1;
            end
        end

        if (!fin)
            return 1'b0;
        window_code = '0;
        window_len = 0;
        if (!is_b)
            return 1'b0;

        // Sum the differences, capping one past the ceiling; clear as we go.
        total = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            diff = (prof_a[i] > prof_b[i]) ? prof_a[i] - prof_b[i] : prof_b[i] - prof_a[i];
            total += diff;
            if (total > DIST_MAX)
                total = DIST_MAX + 1;
            prof_a[i] = 0;
            prof_b[i] = 0;
        end
        if (total > DIST_MAX)
        begin
            res_dist = DIST_MAX;
            sat = 1'b1;
        end
        else
        begin
            res_dist = DIST_BITS'(total);
            sat = hit_ceiling;
        end
        hit_ceiling = 1'b0;
        return 1'b1;
    endfunction

    // Sample at the edge: check the result, track config, predict each request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_distances.size() == 0)
                begin
                    $error("unexpected result: distance %0d saturated %0d", distance, saturated);
                    mismatches++;
                end
                else
                begin
                    if (distance !== pending_distances[0].distance)
                    begin
                        $error("distance: expected %0d, actual %0d",
                               pending_distances[0].distance, distance);
                        mismatches++;
                    end
                    if (saturated !== pending_distances[0].saturated)
                    begin
                        $error("saturated: expected %0d, actual %0d",
                               pending_distances[0].saturated, saturated);
                        mismatches++;
                    end
                    void'(pending_distances.pop_front());
                end
            end
            if (cfg_we)
                gram_q = cfg_wdata;
            if (start && !busy)
            begin
                if (tally_symbol(cmd, symbol, last, pred_dist, pred_sat))
                begin
                    if (typed_now)
                        pending_distances.push_back('{distance: typed_dist,
                                                      saturated: typed_sat});
                    else
                        pending_distances.push_back('{distance: pred_dist,
                                                      saturated: pred_sat});
                end
            end
        end
    end

    // Present one request, after an optional random idle gap, and hold it until taken.
    task automatic issue(input logic seq, input logic [SYMBOL_W-1:0] sym, input logic fin,
                         input logic typed, input logic [DIST_BITS-1:0] exp_dist,
                         input logic sat);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 35)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= seq;
        symbol     <= sym;
        last       <= fin;
        typed_now  <= typed;
        typed_dist <= exp_dist;
        typed_sat  <= sat;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Write gram_length once nothing is owed and the block has gone idle.
    task automatic write_gram_length(input logic [Q_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [SYMBOL_W-1:0] seq_a [$];
        logic [SYMBOL_W-1:0] seq_b [$];
        int                  sent;
        int                  len;
        int                  burst;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_GRAM_LENGTH)
                write_gram_length(directed_rows[r].q_value);
            else
                issue(directed_rows[r].seq, directed_rows[r].sym, directed_rows[r].fin,
                      directed_rows[r].typed, directed_rows[r].exp_dist,
                      directed_rows[r].sat);
        end

        // Random part: mostly A/B pairs, some with B a mutated copy of A,
        // mixed with bursts of raw requests that interleave and end anywhere.
        sent = 0;
        while (sent < PAIR_ITEMS)
        begin
            calm = (sent >= 150 && sent < 260);
            if ($urandom_range(0, 7) == 0)
                write_gram_length(Q_W'($urandom_range(0, 7)));

            if ($urandom_range(0, 99) < 75)
            begin
                seq_a.delete();
                seq_b.delete();
                len = $urandom_range(0, 12);
                repeat (len) seq_a.push_back(SYMBOL_W'($urandom_range(0, 3)));
                if (len > 0 && $urandom_range(0, 1) == 1)
                begin
                    foreach (seq_a[i])
                        seq_b.push_back(($urandom_range(0, 4) == 0) ?
                                        SYMBOL_W'($urandom_range(0, 3)) : seq_a[i]);
                end
                else
                begin
                    len = $urandom_range(1, 12);
                    repeat (len) seq_b.push_back(SYMBOL_W'($urandom_range(0, 3)));
                end
                foreach (seq_a[i])
                    issue(SEQ_A, seq_a[i], i == seq_a.size() - 1, 1'b0, '0, 1'b0);
                foreach (seq_b[i])
                    issue(SEQ_B, seq_b[i], i == seq_b.size() - 1, 1'b0, '0, 1'b0);
                sent += seq_a.size() + seq_b.size();
            end
            else
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                    issue(1'($urandom_range(0, 1)), SYMBOL_W'($urandom_range(0, 3)),
                          $urandom_range(0, 4) == 0, 1'b0, '0, 1'b0);
                sent += burst;
            end
        end

        // Drain: drop start, wait for every owed distance, then settle.
        start <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("qgram_profile_distance test passed");
        else
            $display("qgram_profile_distance test failed");
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial
    begin
        #(40_000_000);
        $display("qgram_profile_distance test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/qpd_pkg.sv
sv/qgram_profile_distance.sv
sv/qpd_checker.sv
test/tb.sv
